/* src/per_source_peak_rate_monitor_unit_macros.svh */
// assertion macros for the per-source peak rate monitor
// clocked by aclk and disabled while aresetn is low in the module that uses them
`ifndef PER_SOURCE_PEAK_RATE_MONITOR_UNIT_MACROS_SVH
`define PER_SOURCE_PEAK_RATE_MONITOR_UNIT_MACROS_SVH

`ifndef SYNTH

`define PSPRM_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("psprm assertion failed");

`define PSPRM_ASSERT_NEVER(label, cond) \
    `PSPRM_ASSERT(label, !(cond))

`else

`define PSPRM_ASSERT(label, prop)

`define PSPRM_ASSERT_NEVER(label, cond)

`endif

`endif

/* src/psprm_pkg.sv */
// shared types and constants of the per-source peak rate monitor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package psprm_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    localparam int ID_W    = 32;
    localparam int CNT_W   = 32;
    localparam int TS_W    = 64;
    localparam int LEN_W   = 40;
    localparam int SEL_W   = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET = LEN_W'(64'd1000000000);
    localparam logic [TS_W-1:0]  WINDOW_ORIGIN_RESET = '0;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ORIGIN = 1'd1;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  owner;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] peak;
    } tbl_rd_t;

    typedef struct packed {
        logic             owner_we;
        logic [ID_W-1:0]  owner;
        logic             count_we;
        logic [CNT_W-1:0] count;
        logic             peak_we;
        logic [CNT_W-1:0] peak;
    } tbl_wr_t;

    typedef struct packed {
        logic [SEL_W-1:0] slot_used;
        logic             counted;
        logic             table_full;
        logic             window_closed;
        logic [ID_W-1:0]  read_owner;
        logic [CNT_W-1:0] read_peak;
    } result_t;

endpackage

`default_nettype wire

/* src/psprm_slot_table.sv */
// slot table: owner, window count and peak per slot, one access port
// depends on psprm_pkg
`timescale 1ns / 1ps
`default_nettype none

module psprm_slot_table (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [psprm_pkg::SLOT_W-1:0] idx,
    input  wire psprm_pkg::tbl_wr_t          wr,
    output psprm_pkg::tbl_rd_t               rd
);

    logic [psprm_pkg::ID_W-1:0]  owner_reg [psprm_pkg::SLOTS];
    logic [psprm_pkg::CNT_W-1:0] count_reg [psprm_pkg::SLOTS];
    logic [psprm_pkg::CNT_W-1:0] peak_reg  [psprm_pkg::SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < psprm_pkg::SLOTS; i++) begin
                owner_reg[i] <= '0;
                count_reg[i] <= '0;
                peak_reg[i]  <= '0;
            end
        end else begin
            if (wr.owner_we) begin
                owner_reg[idx] <= wr.owner;
            end
            if (wr.count_we) begin
                count_reg[idx] <= wr.count;
            end
            if (wr.peak_we) begin
                peak_reg[idx] <= wr.peak;
            end
        end
    end

    assign rd.owner = owner_reg[idx];
    assign rd.count = count_reg[idx];
    assign rd.peak  = peak_reg[idx];

endmodule

`default_nettype wire

/* src/psprm_seq.sv */
// sequencer: slot scan, window check, close-out walk and slot read over the slot table
// depends on psprm_pkg; drives the single access port of psprm_slot_table
`timescale 1ns / 1ps
`default_nettype none

module psprm_seq (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_command,
    input  wire logic [psprm_pkg::ID_W-1:0]   s_source_id,
    input  wire logic [psprm_pkg::TS_W-1:0]   s_now_ns,
    input  wire logic [psprm_pkg::SEL_W-1:0]  s_slot_select,
    input  wire logic [psprm_pkg::LEN_W-1:0]  window_length,
    input  wire logic [psprm_pkg::TS_W-1:0]   window_origin,
    output logic [psprm_pkg::SLOT_W-1:0]      tbl_idx,
    output psprm_pkg::tbl_wr_t                tbl_wr,
    input  wire psprm_pkg::tbl_rd_t           tbl_rd,
    output logic                              done_valid,
    input  wire logic                         done_ready,
    output psprm_pkg::result_t                done_result
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_CLOSE = 6'b001000,
        ST_READ  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [psprm_pkg::SLOT_W-1:0]    ptr_reg, ptr_next;
    logic [psprm_pkg::ID_W-1:0]      id_reg, id_next;
    logic [psprm_pkg::TS_W-1:0]      now_reg, now_next;
    psprm_pkg::result_t              res_reg, res_next;
    logic [psprm_pkg::TS_W-1:0]      start_reg, start_next;
    logic                            started_reg, started_next;

    logic [psprm_pkg::TS_W-1:0]      elapsed;

    // modular distance from the current window start
    assign elapsed = now_reg - (started_reg ? start_reg : window_origin);

    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        id_next      = id_reg;
        now_next     = now_reg;
        res_next     = res_reg;
        start_next   = start_reg;
        started_next = started_reg;
        tbl_wr       = '0;
        done_valid   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    id_next  = s_source_id;
                    now_next = s_now_ns;
                    res_next = '0;
                    if (s_command == psprm_pkg::CMD_READ) begin
                        res_next.slot_used = s_slot_select;
                        ptr_next           = psprm_pkg::SLOT_W'(s_slot_select);
                        state_next         = ST_READ;
                    end else if (s_source_id == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        ptr_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (tbl_rd.owner == id_reg || tbl_rd.owner == '0) begin
                    // an empty slot always holds a zero count
                    tbl_wr.owner_we = 1'b1;
                    tbl_wr.owner    = id_reg;
                    tbl_wr.count_we = 1'b1;
                    tbl_wr.count    = (&tbl_rd.count) ? tbl_rd.count
                                                      : tbl_rd.count + 1'b1;
                    res_next.counted   = 1'b1;
                    res_next.slot_used = psprm_pkg::SEL_W'(ptr_reg);
                    state_next         = ST_CHECK;
                end else if (ptr_reg == psprm_pkg::SLOT_LAST) begin
                    res_next.table_full = 1'b1;
                    state_next          = ST_DONE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_CHECK: begin
                if (elapsed >= {{(psprm_pkg::TS_W - psprm_pkg::LEN_W){1'b0}},
                                window_length}) begin
                    res_next.window_closed = 1'b1;
                    start_next             = now_reg;
                    started_next           = 1'b1;
                    ptr_next               = '0;
                    state_next             = ST_CLOSE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CLOSE: begin
                tbl_wr.count_we = 1'b1;
                tbl_wr.count    = '0;
                if (tbl_rd.count != '0 && tbl_rd.count > tbl_rd.peak) begin
                    tbl_wr.peak_we = 1'b1;
                    tbl_wr.peak    = tbl_rd.count;
                end
                if (ptr_reg == psprm_pkg::SLOT_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_READ: begin
                if (32'(res_reg.slot_used) < 32'(psprm_pkg::SLOTS)) begin
                    res_next.read_owner = tbl_rd.owner;
                    res_next.read_peak  = tbl_rd.peak;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                done_valid = 1'b1;
                if (done_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= '0;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        id_reg  <= id_next;
        now_reg <= now_next;
        res_reg <= res_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign tbl_idx     = ptr_reg;
    assign done_result = res_reg;

endmodule

`default_nettype wire

/* src/per_source_peak_rate_monitor_unit.sv */
// Per-source peak rate monitor. A record transfer (command 0) looks up or claims
// a slot for its source id, one slot per cycle, bumps that slot's window count
// and then checks the window; a window close walks all 16 slots, one per cycle,
// folding counts into peaks. A full table ends after the scan, a rejected id
// (zero) goes straight to the result and a read (command 1) reads its slot first.
// The slots are visited one at a time over the single table port. The block takes
// no new transfer until its result has moved into the output register; the next
// transfer is taken while a result still waits in the output register.
// Depends on psprm_pkg, psprm_seq, psprm_slot_table and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "per_source_peak_rate_monitor_unit_macros.svh"

module per_source_peak_rate_monitor_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [psprm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [psprm_pkg::TS_W-1:0]      cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_command,
    input  wire logic [psprm_pkg::ID_W-1:0]      s_source_id,
    input  wire logic [psprm_pkg::TS_W-1:0]      s_now_ns,
    input  wire logic [psprm_pkg::SEL_W-1:0]     s_slot_select,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [psprm_pkg::SEL_W-1:0]          m_slot_used,
    output logic                                 m_counted,
    output logic                                 m_table_full,
    output logic                                 m_window_closed,
    output logic [psprm_pkg::ID_W-1:0]           m_read_owner,
    output logic [psprm_pkg::CNT_W-1:0]          m_read_peak
);

    logic [psprm_pkg::LEN_W-1:0]  length_reg;
    logic [psprm_pkg::TS_W-1:0]   origin_reg;

    logic [psprm_pkg::SLOT_W-1:0] tbl_idx;
    psprm_pkg::tbl_wr_t           tbl_wr;
    psprm_pkg::tbl_rd_t           tbl_rd;

    logic                         done_valid;
    logic                         done_ready;
    psprm_pkg::result_t           done_result;

    logic                         out_valid_reg;
    psprm_pkg::result_t           out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= psprm_pkg::WINDOW_LENGTH_RESET;
            origin_reg <= psprm_pkg::WINDOW_ORIGIN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                psprm_pkg::REG_WINDOW_LENGTH: length_reg <= cfg_wdata[psprm_pkg::LEN_W-1:0];
                psprm_pkg::REG_WINDOW_ORIGIN: origin_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    psprm_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_source_id   (s_source_id),
        .s_now_ns      (s_now_ns),
        .s_slot_select (s_slot_select),
        .window_length (length_reg),
        .window_origin (origin_reg),
        .tbl_idx       (tbl_idx),
        .tbl_wr        (tbl_wr),
        .tbl_rd        (tbl_rd),
        .done_valid    (done_valid),
        .done_ready    (done_ready),
        .done_result   (done_result)
    );

    psprm_slot_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .idx     (tbl_idx),
        .wr      (tbl_wr),
        .rd      (tbl_rd)
    );

    // output register frees up as the current result is taken
    assign done_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (done_ready) begin
            out_valid_reg <= done_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_valid && done_ready) begin
            out_reg <= done_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_slot_used     = out_reg.slot_used;
    assign m_counted       = out_reg.counted;
    assign m_table_full    = out_reg.table_full;
    assign m_window_closed = out_reg.window_closed;
    assign m_read_owner    = out_reg.read_owner;
    assign m_read_peak     = out_reg.read_peak;

    `PSPRM_ASSERT_NEVER(a_count_and_full, m_valid && m_counted && m_table_full)
    `PSPRM_ASSERT(a_close_needs_count, (m_valid && m_window_closed) |-> m_counted)
    `PSPRM_ASSERT(a_busy_after_transfer, (s_valid && s_ready) |=> !s_ready)
    `PSPRM_ASSERT_NEVER(a_done_while_idle, done_valid && s_ready)

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// self-checking testbench for per_source_peak_rate_monitor_unit: queued stimulus driver,
// in-line slot table predictor and result checker on the m_ channel
// depends on psprm_pkg and the unit itself
`timescale 1ns / 1ps

module tb_top;
    import psprm_pkg::*;

    typedef struct packed {
        logic             cmd;
        logic [ID_W-1:0]  id;
        logic [TS_W-1:0]  now;
        logic [SEL_W-1:0] sel;
    } item_t;

    localparam int POOL = 22;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TS_W-1:0]      cfg_wdata = '0;

    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_command = CMD_RECORD;
    logic [ID_W-1:0]  s_source_id = '0;
    logic [TS_W-1:0]  s_now_ns = '0;
    logic [SEL_W-1:0] s_slot_select = '0;

    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [SEL_W-1:0] m_slot_used;
    logic             m_counted;
    logic             m_table_full;
    logic             m_window_closed;
    logic [ID_W-1:0]  m_read_owner;
    logic [CNT_W-1:0] m_read_peak;

    per_source_peak_rate_monitor_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_source_id(s_source_id),
        .s_now_ns(s_now_ns),
        .s_slot_select(s_slot_select),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_slot_used(m_slot_used),
        .m_counted(m_counted),
        .m_table_full(m_table_full),
        .m_window_closed(m_window_closed),
        .m_read_owner(m_read_owner),
        .m_read_peak(m_read_peak)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    logic [ID_W-1:0]  own_tab [SLOTS];
    logic [CNT_W-1:0] cnt_tab [SLOTS];
    logic [CNT_W-1:0] peak_tab [SLOTS];
    logic [TS_W-1:0]  win_start;
    logic             win_live;
    logic [LEN_W-1:0] win_len;
    logic [TS_W-1:0]  win_origin;

    item_t   event_q[$];
    result_t outcome_q[$];
    item_t   cur;
    result_t want;
    bit      s_took = 1'b0;
    bit      calm = 1'b0;
    int      errors = 0;
    int      hold_asks = 0;
    int      hold_served = 0;
    int      hold_left = 0;

    logic [ID_W-1:0] id_pool [POOL];
    logic [TS_W-1:0] ts;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic result_t predict_outcome(input item_t it);
        result_t         r;
        int              s;
        logic [TS_W-1:0] start;
        r = '0;
        if (it.cmd == CMD_READ) begin
            r.slot_used = it.sel;
            if (int'(it.sel) < SLOTS) begin
                r.read_owner = own_tab[it.sel];
                r.read_peak = peak_tab[it.sel];
            end
        end else if (it.id != '0) begin
            s = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (s < 0) begin
                    if (own_tab[i] == it.id) begin
                        s = i;
                    end else if (own_tab[i] == '0) begin
                        own_tab[i] = it.id;
                        s = i;
                    end
                end
            end
            if (s < 0) begin
                r.table_full = 1'b1;
            end else begin
                r.counted = 1'b1;
                r.slot_used = SEL_W'(s);
                if (cnt_tab[s] != '1) cnt_tab[s] = cnt_tab[s] + 1'b1;
                start = win_live ? win_start : win_origin;
                if (it.now - start >= {{(TS_W-LEN_W){1'b0}}, win_len}) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (cnt_tab[i] != '0 && cnt_tab[i] > peak_tab[i]) peak_tab[i] = cnt_tab[i];
                        cnt_tab[i] = '0;
                    end
                    win_start = it.now;
                    win_live = 1'b1;
                    r.window_closed = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // input side: predict at the transfer
    always @(posedge aclk) begin
        s_took = aresetn && s_valid && s_ready;
        if (s_took) begin
            outcome_q.push_back(predict_outcome({s_command, s_source_id, s_now_ns, s_slot_select}));
        end
    end

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (event_q.size() != 0 && (calm || $urandom_range(0, 99) >= 17)) begin
                cur = event_q.pop_front();
                s_valid <= 1'b1;
                s_command <= cur.cmd;
                s_source_id <= cur.id;
                s_now_ns <= cur.now;
                s_slot_select <= cur.sel;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver readiness, with one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asks) begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 17);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                $error("unexpected result transfer: slot_used %0d counted %0d",
                       m_slot_used, m_counted);
                errors++;
            end else begin
                want = outcome_q.pop_front();
                if (m_slot_used !== want.slot_used) begin
                    $error("slot_used: expected %0d, got %0d", want.slot_used, m_slot_used);
                    errors++;
                end
                if (m_counted !== want.counted) begin
                    $error("counted: expected %0d, got %0d", want.counted, m_counted);
                    errors++;
                end
                if (m_table_full !== want.table_full) begin
                    $error("table_full: expected %0d, got %0d", want.table_full, m_table_full);
                    errors++;
                end
                if (m_window_closed !== want.window_closed) begin
                    $error("window_closed: expected %0d, got %0d",
                           want.window_closed, m_window_closed);
                    errors++;
                end
                if (m_read_owner !== want.read_owner) begin
                    $error("read_owner: expected %h, got %h", want.read_owner, m_read_owner);
                    errors++;
                end
                if (m_read_peak !== want.read_peak) begin
                    $error("read_peak: expected %0d, got %0d", want.read_peak, m_read_peak);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                             input logic [TS_W-1:0] now, input logic [SEL_W-1:0] sel);
        item_t it;
        it.cmd = cmd;
        it.id = id;
        it.now = now;
        it.sel = sel;
        event_q.push_back(it);
    endtask

    // idle means nothing queued, nothing offered and nothing outstanding
    task automatic wait_drained();
        while (event_q.size() != 0 || s_valid || outcome_q.size() != 0) @(posedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TS_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW_LENGTH) win_len = val[LEN_W-1:0];
        else if (idx == REG_WINDOW_ORIGIN) win_origin = val;
    endtask

    task automatic gen_items(input int n);
        item_t           it;
        int              roll;
        logic [TS_W-1:0] span;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            it.cmd = CMD_RECORD;
            it.sel = SEL_W'($urandom_range(0, 15));
            if (roll < 20) begin
                it.cmd = CMD_READ;
                it.id = $urandom;
                it.now = rand64();
            end else begin
                if (roll < 24) it.id = '0;
                else if (roll < 27) it.id = $urandom;
                else if ($urandom_range(0, 99) < 80) it.id = id_pool[$urandom_range(0, 9)];
                else it.id = id_pool[$urandom_range(0, POOL - 1)];
                // mostly a running timestamp, now and then a jump anywhere
                if ($urandom_range(0, 99) < 5) begin
                    ts = rand64();
                end else begin
                    span = {{(TS_W-LEN_W){1'b0}}, win_len} / 3 + 2;
                    ts = ts + rand64() % span;
                end
                it.now = ts;
            end
            event_q.push_back(it);
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            own_tab[i] = '0;
            cnt_tab[i] = '0;
            peak_tab[i] = '0;
        end
        win_start = '0;
        win_live = 1'b0;
        win_len = WINDOW_LENGTH_RESET;
        win_origin = WINDOW_ORIGIN_RESET;
        for (int i = 0; i < POOL; i++) begin
            do id_pool[i] = $urandom; while (id_pool[i] == '0);
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // empty table reads and a rejected id under reset settings
        send_item(CMD_READ, '1, '1, 4'd0);
        send_item(CMD_READ, '0, '0, 4'd15);
        send_item(CMD_RECORD, '0, '1, 4'd9);
        wait_drained();

        // first window starts at the origin and wraps past zero
        write_reg(REG_WINDOW_LENGTH, 64'h200);
        write_reg(REG_WINDOW_ORIGIN, 64'hFFFF_FFFF_FFFF_FF00);
        send_item(CMD_RECORD, 32'd1, 64'h50, 4'd15);
        send_item(CMD_RECORD, 32'hFFFF_FFFF, 64'hFF, 4'd0);
        send_item(CMD_RECORD, 32'd1, 64'h100, 4'd7);
        send_item(CMD_READ, '0, '0, 4'd0);
        send_item(CMD_READ, '1, '1, 4'd1);
        send_item(CMD_RECORD, '0, 64'h150, 4'd3);
        send_item(CMD_RECORD, 32'd1, 64'h2FF, 4'd0);
        send_item(CMD_RECORD, 32'd1, 64'h300, 4'd15);
        send_item(CMD_READ, 32'hA5A5_5A5A, '1, 4'd0);
        wait_drained();

        // zero length closes on every counted event
        write_reg(REG_WINDOW_LENGTH, 64'd0);
        send_item(CMD_RECORD, 32'd1, 64'd0, 4'd0);
        send_item(CMD_RECORD, 32'hFFFF_FFFF, 64'd0, 4'd0);
        send_item(CMD_RECORD, 32'd1, 64'd0, 4'd0);
        wait_drained();

        // window of 1000000000000, upper write data bits are dropped
        write_reg(REG_WINDOW_LENGTH, {24'hABCDEF, 40'd1000000000000});
        send_item(CMD_RECORD, 32'd1, 64'd999999999999, 4'd0);
        send_item(CMD_RECORD, 32'd1, 64'd1000000000000, 4'd0);
        send_item(CMD_READ, '0, '0, 4'd0);
        wait_drained();

        // window length of one
        write_reg(REG_WINDOW_LENGTH, 64'd1);
        ts = rand64();
        gen_items(60);
        wait_drained();

        // reset length, origin no longer matters, no idling at all
        write_reg(REG_WINDOW_LENGTH, 64'd1000000000);
        write_reg(REG_WINDOW_ORIGIN, rand64());
        calm = 1'b1;
        gen_items(120);
        wait_drained();
        calm = 1'b0;

        // window of 1000000000000 with the receiver holding off for a while
        write_reg(REG_WINDOW_LENGTH, 64'd1000000000000);
        gen_items(80);
        hold_asks = hold_asks + 1;
        wait_drained();

        write_reg(REG_WINDOW_LENGTH, rand64());
        write_reg(REG_WINDOW_ORIGIN, rand64());
        gen_items(100);
        wait_drained();

        write_reg(REG_WINDOW_LENGTH, 64'($urandom_range(1, 5000)));
        gen_items(90);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

/* per_source_peak_rate_monitor_unit.f */
+incdir+src
src/psprm_pkg.sv
src/psprm_slot_table.sv
src/psprm_seq.sv
src/per_source_peak_rate_monitor_unit.sv
dv/tb_top.sv
